// ===== design/sknn_pkg.sv =====
`default_nettype none
package sknn_pkg;

	localparam int MAX_K       = 16;
	localparam int MAX_POINTS  = 1024;
	localparam int CNT_W       = $clog2(MAX_K + 1);
	localparam int DIST_W      = 32;
	localparam int ID_W        = $clog2(MAX_POINTS);
	localparam int KCFG_W      = 5;
	localparam int RANK_W      = 4;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic [ID_W-1:0]   point_id;
		logic              last_item;
	} rec_t;

	// head of the record queue, as seen by the back end
	typedef struct packed {
		logic valid;
		rec_t rec;
	} q_head_t;

	typedef enum logic [1:0] {
		ST_LOAD  = 2'b01,
		ST_DRAIN = 2'b10
	} back_state_t;

	// zero selects one, anything above the store depth saturates
	function automatic logic [CNT_W-1:0] eff_k(input logic [KCFG_W-1:0] k);
		logic [CNT_W-1:0] r;
		if (k == '0) begin
			r = CNT_W'(1);
		end else if (32'(k) > MAX_K) begin
			r = CNT_W'(MAX_K);
		end else begin
			r = CNT_W'(k);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/sknn_rec_if.sv =====
`default_nettype none
interface sknn_rec_if import sknn_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] distance;
	logic [ID_W-1:0]   point_id;
	logic              last_item;

	modport source (output valid, output distance, output point_id, output last_item,
		input ready);
	modport sink (input valid, input distance, input point_id, input last_item,
		output ready);
endinterface
`default_nettype wire

// ===== design/sknn_sel_if.sv =====
`default_nettype none
interface sknn_sel_if import sknn_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] sel_distance;
	logic [ID_W-1:0]   sel_point_id;
	logic [RANK_W-1:0] rank;
	logic              last_result;

	modport source (output valid, output sel_distance, output sel_point_id, output rank,
		output last_result, input ready);
	modport sink (input valid, input sel_distance, input sel_point_id, input rank,
		input last_result, output ready);
endinterface
`default_nettype wire

// ===== design/sknn_cfg_if.sv =====
`default_nettype none
interface sknn_cfg_if import sknn_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KCFG_W-1:0] k_count;

	modport source (output valid, output k_count, input ready);
	modport sink (input valid, input k_count, output ready);
endinterface
`default_nettype wire

// ===== design/sknn_front.sv =====
`default_nettype none
module sknn_front import sknn_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	sknn_rec_if.sink     rec_in,
	output q_head_t      head,
	input  wire logic    pop
);

	rec_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              do_pop;

	assign rec_in.ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign push         = rec_in.valid && rec_in.ready;
	assign do_pop       = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.rec   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{distance: rec_in.distance, point_id: rec_in.point_id,
				last_item: rec_in.last_item};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("record queue overfilled");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("pop from empty record queue");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !do_pop) |=> (count_q == $past(count_q) + QCNT_W'(1)))
		else $error("queue count lost a transaction");

endmodule
`default_nettype wire

// ===== design/sknn_back.sv =====
`default_nettype none
module sknn_back import sknn_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [CNT_W-1:0]  k_eff,
	input  q_head_t                head,
	output logic                   pop,
	sknn_sel_if.source             sel_out
);

	back_state_t       state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RANK_W-1:0] rank_q;
	logic [DIST_W-1:0] dist_q [MAX_K];
	logic [ID_W-1:0]   id_q   [MAX_K];

	logic              out_valid_q;
	logic [DIST_W-1:0] out_dist_q;
	logic [ID_W-1:0]   out_id_q;
	logic [RANK_W-1:0] out_rank_q;
	logic              out_last_q;

	logic [CNT_W-1:0]  cnt_eff;
	logic [MAX_K-1:0]  le;
	logic [CNT_W-1:0]  pos;
	logic              ins_en;
	logic [CNT_W-1:0]  cnt_ins;
	logic [DIST_W-1:0] up_d   [MAX_K];
	logic [ID_W-1:0]   up_id  [MAX_K];
	logic [DIST_W-1:0] ins_d  [MAX_K];
	logic [ID_W-1:0]   ins_id [MAX_K];
	logic [DIST_W-1:0] dn_d   [MAX_K];
	logic [ID_W-1:0]   dn_id  [MAX_K];
	logic              out_load;
	logic              drain_last;

	assign pop      = head.valid && (state_q == ST_LOAD);
	assign cnt_eff  = (cnt_q > k_eff) ? k_eff : cnt_q;
	assign pos      = CNT_W'($countones(le));
	assign ins_en   = pop && (pos < k_eff);
	assign cnt_ins  = ins_en ? ((cnt_eff < k_eff) ? cnt_eff + CNT_W'(1) : k_eff) : cnt_eff;

	assign out_load   = (state_q == ST_DRAIN) && (!out_valid_q || sel_out.ready);
	assign drain_last = (cnt_q == CNT_W'(1));

	// held list is sorted, so the entries at or below the new distance form a prefix
	always_comb begin
		for (int i = 0; i < MAX_K; i++) begin
			le[i] = (CNT_W'(i) < cnt_eff) && (dist_q[i] <= head.rec.distance);
		end
	end

	always_comb begin
		up_d[0]  = head.rec.distance;
		up_id[0] = head.rec.point_id;
		dn_d[MAX_K-1]  = dist_q[MAX_K-1];
		dn_id[MAX_K-1] = id_q[MAX_K-1];
		for (int i = 1; i < MAX_K; i++) begin
			up_d[i]    = dist_q[i-1];
			up_id[i]   = id_q[i-1];
			dn_d[i-1]  = dist_q[i];
			dn_id[i-1] = id_q[i];
		end
		for (int i = 0; i < MAX_K; i++) begin
			if (CNT_W'(i) < pos) begin
				ins_d[i]  = dist_q[i];
				ins_id[i] = id_q[i];
			end else if (CNT_W'(i) == pos) begin
				ins_d[i]  = head.rec.distance;
				ins_id[i] = head.rec.point_id;
			end else begin
				ins_d[i]  = up_d[i];
				ins_id[i] = up_id[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ins_en) begin
			dist_q <= ins_d;
			id_q   <= ins_id;
		end else if (out_load) begin
			dist_q <= dn_d;
			id_q   <= dn_id;
		end
		if (out_load) begin
			out_dist_q <= dist_q[0];
			out_id_q   <= id_q[0];
			out_rank_q <= rank_q;
			out_last_q <= drain_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			rank_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (sel_out.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (pop) begin
						cnt_q <= cnt_ins;
						if (head.rec.last_item) begin
							state_q <= ST_DRAIN;
							rank_q  <= '0;
						end
					end
				end
				ST_DRAIN: begin
					// shift the head entry out, one transaction per cycle while sel_out is ready
					if (out_load) begin
						cnt_q  <= cnt_q - CNT_W'(1);
						rank_q <= rank_q + RANK_W'(1);
						if (drain_last) begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign sel_out.valid        = out_valid_q;
	assign sel_out.sel_distance = out_dist_q;
	assign sel_out.sel_point_id = out_id_q;
	assign sel_out.rank         = out_rank_q;
	assign sel_out.last_result  = out_last_q;

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (cnt_q != '0))
		else $error("drain entered with empty list");

	a_sorted_pair: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_LOAD) && (cnt_q >= CNT_W'(2))) |-> (dist_q[0] <= dist_q[1]))
		else $error("held list out of order");

	a_last_ends_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && drain_last) |=> ((state_q == ST_LOAD) && (cnt_q == '0)))
		else $error("final result did not empty the list");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_K))
		else $error("held count above store depth");

endmodule
`default_nettype wire

// ===== design/select_k_nearest.sv =====
// Streaming k-smallest selector. Records (distance, point_id) arrive one per transaction
// and enter a 4-deep queue; while loading, the back end takes one record per cycle from
// it into a sorted list of up to 16 entries, where all held entries are compared against
// the new distance in parallel. Equal distances keep arrival order. After the record
// marked last_item, the back end shifts the held records out in ascending order, one
// result per cycle while sel_out is ready, with rank counting from 0 and last_result on
// the final one (k results, fewer if the set was shorter); the list is then empty for
// the next set. During that drain the queue keeps taking records until it fills. The
// user writes k_count (reset 1) through cfg while the block is idle; the block itself
// does not enforce this. 0 acts as 1 and values above 16 act as 16. cfg is always ready.
`default_nettype none
module select_k_nearest import sknn_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sknn_cfg_if.sink   cfg,
	sknn_rec_if.sink   rec_in,
	sknn_sel_if.source sel_out
);

	logic [KCFG_W-1:0] k_q;
	logic [CNT_W-1:0]  k_eff;
	q_head_t           head;
	logic              pop;

	assign cfg.ready = 1'b1;
	assign k_eff     = eff_k(k_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= KCFG_W'(1);
		end else if (cfg.valid) begin
			k_q <= cfg.k_count;
		end
	end

	sknn_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rec_in (rec_in),
		.head   (head),
		.pop    (pop)
	);

	sknn_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.k_eff   (k_eff),
		.head    (head),
		.pop     (pop),
		.sel_out (sel_out)
	);

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import sknn_pkg::*;

	localparam int LONG_HOLD    = 150;
	localparam int SETTLE_TICKS = 24;
	localparam int RANDOM_ITEMS = 100;

	typedef struct {
		logic [DIST_W-1:0] distance;
		logic [ID_W-1:0]   id;
		logic [RANK_W-1:0] rank;
		logic              last;
	} selection_t;

	// keeps its own sorted list of the nearest records and the selections they lead to
	class nearest_board;
		logic [DIST_W-1:0] kept_dist [MAX_K];
		logic [ID_W-1:0]   kept_id [MAX_K];
		int unsigned       kept_n;
		logic [KCFG_W-1:0] k_setting;
		selection_t        pending_sel [$];
		int unsigned       mismatches;
		int unsigned       records_taken;
		int unsigned       sets_closed;
		int unsigned       selections_checked;

		function new();
			kept_n = 0;
			k_setting = KCFG_W'(1);
			mismatches = 0;
			records_taken = 0;
			sets_closed = 0;
			selections_checked = 0;
		endfunction

		function void take_record(logic [DIST_W-1:0] d, logic [ID_W-1:0] id, logic last);
			int unsigned k;
			int unsigned pos;
			int unsigned top;
			selection_t s;
			records_taken++;
			k = (k_setting == 0) ? 1 : ((k_setting > MAX_K) ? MAX_K : k_setting);
			// drop the largest entries when k was lowered in mid-set
			if (kept_n > k) begin
				kept_n = k;
			end
			pos = 0;
			while (pos < kept_n && kept_dist[pos] <= d) begin
				pos++;
			end
			if (pos < k) begin
				top = (kept_n < k) ? kept_n : k - 1;
				for (int unsigned i = top; i > pos; i--) begin
					kept_dist[i] = kept_dist[i-1];
					kept_id[i] = kept_id[i-1];
				end
				kept_dist[pos] = d;
				kept_id[pos] = id;
				if (kept_n < k) begin
					kept_n++;
				end
			end
			if (last) begin
				for (int unsigned i = 0; i < kept_n; i++) begin
					s.distance = kept_dist[i];
					s.id = kept_id[i];
					s.rank = RANK_W'(i);
					s.last = (i + 1 == kept_n);
					pending_sel.push_back(s);
				end
				kept_n = 0;
				sets_closed++;
			end
		endfunction

		function void check_selection(logic [DIST_W-1:0] d, logic [ID_W-1:0] id,
				logic [RANK_W-1:0] rank, logic last);
			selection_t exp_sel;
			bit bad;
			selections_checked++;
			if (pending_sel.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: unexpected selection dist=%h id=%0d rank=%0d last=%b",
						$realtime, d, id, rank, last);
				end
				return;
			end
			exp_sel = pending_sel.pop_front();
			bad = 0;
			if (d !== exp_sel.distance) bad = 1;
			if (id !== exp_sel.id) bad = 1;
			if (rank !== exp_sel.rank) bad = 1;
			if (last !== exp_sel.last) bad = 1;
			if (bad) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: selection mismatch exp dist=%h id=%0d rank=%0d last=%b",
						$realtime, exp_sel.distance, exp_sel.id, exp_sel.rank, exp_sel.last);
					$display("%0t:                    got dist=%h id=%0d rank=%0d last=%b",
						$realtime, d, id, rank, last);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	sknn_cfg_if cfg_bus ();
	sknn_rec_if rec_bus ();
	sknn_sel_if sel_bus ();

	select_k_nearest i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_bus),
		.rec_in  (rec_bus),
		.sel_out (sel_bus)
	);

	nearest_board board = new();

	bit tx_burst;
	bit hold_request;
	int unsigned random_records;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic send_record(logic [DIST_W-1:0] d, logic [ID_W-1:0] id, logic last);
		int unsigned gap;
		gap = tx_burst ? 0 : pick_gap();
		if (gap > 0) begin
			rec_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rec_bus.valid <= 1'b1;
		rec_bus.distance <= d;
		rec_bus.point_id <= id;
		rec_bus.last_item <= last;
		do begin
			@(posedge clk);
		end while (!rec_bus.ready);
		board.take_record(d, id, last);
	endtask

	// wait for every selection, then let the input queue run dry
	task automatic settle();
		rec_bus.valid <= 1'b0;
		while (board.pending_sel.size() != 0) @(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic write_k(logic [KCFG_W-1:0] v);
		cfg_bus.valid <= 1'b1;
		cfg_bus.k_count <= v;
		do begin
			@(posedge clk);
		end while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		board.k_setting = v;
	endtask

	task automatic send_set(int unsigned len, int unsigned spread);
		logic [DIST_W-1:0] d;
		int unsigned mode;
		for (int unsigned i = 0; i < len; i++) begin
			mode = (spread == 3) ? $urandom_range(0, 2) : spread;
			case (mode)
				0: d = $urandom;
				1: d = DIST_W'($urandom_range(0, 15));
				default: d = {28'hFFFF_FFF, 4'($urandom_range(0, 15))};
			endcase
			send_record(d, ID_W'($urandom_range(0, MAX_POINTS - 1)), i + 1 == len);
		end
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int unsigned stall_left;
		int unsigned hold_left;
		bit rx_burst;
		stall_left = 0;
		hold_left = 0;
		rx_burst = 0;
		sel_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 0;
				hold_left = LONG_HOLD;
				sel_bus.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				sel_bus.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				sel_bus.ready <= 1'b0;
			end else begin
				sel_bus.ready <= 1'b1;
				if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
				if (!rx_burst && $urandom_range(0, 2) == 0) stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && sel_bus.valid && sel_bus.ready) begin
			board.check_selection(sel_bus.sel_distance, sel_bus.sel_point_id, sel_bus.rank,
				sel_bus.last_result);
		end
	end

	initial begin
		#4_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		int unsigned k_pick;
		int unsigned n_sets;
		int unsigned len;
		tx_burst = 0;
		hold_request = 0;
		random_records = 0;
		arst_n <= 1'b0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.k_count <= '0;
		rec_bus.valid <= 1'b0;
		rec_bus.distance <= '0;
		rec_bus.point_id <= '0;
		rec_bus.last_item <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// k from reset: the earlier of two zero distances wins
		send_record(32'hFFFF_FFFF, 10'd1023, 1'b0);
		send_record(32'h0, 10'd0, 1'b0);
		send_record(32'h0, 10'd5, 1'b1);
		settle();

		// set shorter than k, with ties
		write_k(5'd16);
		send_record(32'd7, 10'd1, 1'b0);
		send_record(32'd3, 10'd2, 1'b0);
		send_record(32'd7, 10'd3, 1'b0);
		send_record(32'hFFFF_FFFF, 10'd4, 1'b0);
		send_record(32'd3, 10'd5, 1'b1);
		settle();

		write_k(5'd0);
		send_record(32'h8000_0000, 10'd512, 1'b0);
		send_record(32'h7FFF_FFFF, 10'd511, 1'b1);
		settle();

		// a record equal to the k-th held one is dropped
		write_k(5'd3);
		send_record(32'd10, 10'd1, 1'b0);
		send_record(32'd20, 10'd2, 1'b0);
		send_record(32'd30, 10'd3, 1'b0);
		send_record(32'd30, 10'd4, 1'b0);
		send_record(32'd25, 10'd5, 1'b1);
		settle();

		// lower k in the middle of a set
		write_k(5'd5);
		send_record(32'd50, 10'd10, 1'b0);
		send_record(32'd40, 10'd11, 1'b0);
		send_record(32'd60, 10'd12, 1'b0);
		send_record(32'd45, 10'd13, 1'b0);
		settle();
		write_k(5'd2);
		send_record(32'd47, 10'd14, 1'b1);
		settle();

		// stall the results long enough to back up the input
		write_k(5'd16);
		tx_burst = 1;
		hold_request = 1;
		send_set(20, 0);
		send_set(12, 1);
		tx_burst = 0;
		random_records = 32;
		settle();

		write_k(5'd31);
		send_set(18, 3);
		random_records += 18;

		while (random_records < RANDOM_ITEMS) begin
			settle();
			k_pick = $urandom_range(0, 9);
			case (k_pick)
				0: write_k(5'd0);
				1: write_k(5'd31);
				2: write_k(5'd16);
				3: write_k(5'd1);
				default: write_k(KCFG_W'($urandom_range(2, 20)));
			endcase
			n_sets = $urandom_range(1, 3);
			for (int unsigned s = 0; s < n_sets; s++) begin
				tx_burst = ($urandom_range(0, 3) == 0);
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 24) :
					$urandom_range(1, 10);
				send_set(len, $urandom_range(0, 3));
				random_records += len;
			end
		end
		tx_burst = 0;
		settle();
		repeat (40) @(posedge clk);

		$display("Checked %0d selections from %0d records in %0d sets.",
			board.selections_checked, board.records_taken, board.sets_closed);
		$display("k ran over 0, 1, 16, 31 and random values, with ties, a mid-set cut"
			, " and a long result stall.");
		if (board.mismatches != 0) begin
			$display("%0d selection mismatches", board.mismatches);
		end
		if (board.pending_sel.size() != 0) begin
			$display("%0d expected selections never arrived", board.pending_sel.size());
		end
		if (board.mismatches == 0 && board.pending_sel.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
